### design/srg3d_pkg.sv
// Package for the staggered-grid 3-D restriction unit.
// Holds shared widths, register indexes, state and axis codes, and the
// command and status structs between controller and datapath. No dependencies.
package srg3d_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int MID_W      = 28;
  localparam int WT_W       = 16;
  localparam int PROD_W     = WT_W + MID_W;
  localparam int ACC_W      = PROD_W + 3;
  localparam int COORD_W    = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = 48;
  localparam int NUM_TAPS   = 5;

  localparam int MAX_ROW_LEN_DEF = 256;
  localparam int MAX_ROWS_DEF    = 256;
  localparam int MAX_PLANES_DEF  = 256;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWLEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WT0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WT1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WT2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WT3 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WT4 = 3'd7;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MUL,
    S_ACC,
    S_RND,
    S_WR,
    S_EMIT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic       load;
    logic       rd;
    logic       mul;
    logic       acc;
    logic       rnd;
    logic       wr;
    logic       emit;
    logic       fin;
    axis_t      axis;
    logic [2:0] tap;
  } cmd_t;

  typedef struct packed {
    logic       drop;
    logic       xok;
    logic       yok;
    logic       zok;
    logic       out_free;
    logic [2:0] ord;
  } sts_t;

endpackage

### design/staggered_grid_restriction_3d_unit.sv
// Top level of the staggered-grid 3-D restriction unit.
// Instantiates srg3d_ctrl, srg3d_dp and two srg3d_ram stores; depends on srg3d_pkg.
//
// Fine samples enter one beat at a time in raster order, x fastest, with
// in_tlast on the last sample of a grid. A sample that completes no x tap
// group goes from idle straight to the finish state. Each filter pass along
// an axis runs through one shared multiplier, with a read, multiply and
// accumulate step per tap and a rounding step at the end. A sample that
// completes an x tap group is filtered along x, then along y and z where
// those tap groups also complete; a coarse point is emitted when the z
// group completes. A finished coarse point waits in the output register
// while the next sample is taken; a later point waits until the output
// register is free. The row and plane stores need no clearing after reset.
module staggered_grid_restriction_3d_unit #(
  parameter int MAX_ROW_LEN = srg3d_pkg::MAX_ROW_LEN_DEF,
  parameter int MAX_ROWS    = srg3d_pkg::MAX_ROWS_DEF,
  parameter int MAX_PLANES  = srg3d_pkg::MAX_PLANES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // fine_sample
  input  logic [srg3d_pkg::SAMPLE_W-1:0]      in_tdata,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // coarse_value [23:0], coarse_x [30:24], coarse_y [37:31], coarse_z [44:38]
  output logic [srg3d_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                                cfg_we,
  input  logic [srg3d_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [srg3d_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import srg3d_pkg::*;

  localparam int CX  = MAX_ROW_LEN / 2;
  localparam int CY  = MAX_ROWS / 2;
  localparam int RAW = $clog2(4 * CX);
  localparam int PAW = $clog2(4 * CX * CY);

  cmd_t             cmd;
  sts_t             sts;
  logic             row_re, row_we, plane_re, plane_we;
  logic [RAW-1:0]   row_raddr, row_waddr;
  logic [PAW-1:0]   plane_raddr, plane_waddr;
  logic [MID_W-1:0] row_rdata, row_wdata, plane_rdata, plane_wdata;

  srg3d_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  srg3d_dp #(
    .MAX_ROW_LEN (MAX_ROW_LEN),
    .MAX_ROWS    (MAX_ROWS),
    .MAX_PLANES  (MAX_PLANES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .sts         (sts),
    .row_re      (row_re),
    .row_raddr   (row_raddr),
    .row_rdata   (row_rdata),
    .row_we      (row_we),
    .row_waddr   (row_waddr),
    .row_wdata   (row_wdata),
    .plane_re    (plane_re),
    .plane_raddr (plane_raddr),
    .plane_rdata (plane_rdata),
    .plane_we    (plane_we),
    .plane_waddr (plane_waddr),
    .plane_wdata (plane_wdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  srg3d_ram #(
    .WIDTH (MID_W),
    .DEPTH (4 * CX)
  ) u_row_store (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .re    (row_re),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  srg3d_ram #(
    .WIDTH (MID_W),
    .DEPTH (4 * CX * CY)
  ) u_plane_store (
    .clk   (clk),
    .we    (plane_we),
    .waddr (plane_waddr),
    .wdata (plane_wdata),
    .re    (plane_re),
    .raddr (plane_raddr),
    .rdata (plane_rdata)
  );

endmodule

### design/srg3d_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the row store and the plane store. No dependencies.
module srg3d_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/srg3d_ctrl.sv
// Controller state machine for the restriction unit.
// Sequences the tap passes along x, y and z; depends on srg3d_pkg.
module srg3d_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  srg3d_pkg::sts_t  sts,
  output srg3d_pkg::cmd_t  cmd
);
  import srg3d_pkg::*;

  state_t     state_r, state_nxt;
  axis_t      axis_r, axis_nxt;
  logic [2:0] tap_r, tap_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= AXIS_X;
      tap_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      tap_r   <= tap_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    tap_nxt   = tap_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          axis_nxt = AXIS_X;
          tap_nxt  = 3'd0;
          if (!sts.drop && sts.xok) begin
            state_nxt = S_RD;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_RD:  state_nxt = S_MUL;
      S_MUL: state_nxt = S_ACC;
      S_ACC: begin
        if (tap_r == sts.ord) begin
          state_nxt = S_RND;
        end else begin
          tap_nxt   = tap_r + 3'd1;
          state_nxt = S_RD;
        end
      end
      S_RND: begin
        tap_nxt = 3'd0;
        case (axis_r)
          AXIS_X: begin
            if (sts.yok) begin
              axis_nxt  = AXIS_Y;
              state_nxt = S_RD;
            end else begin
              state_nxt = S_WR;
            end
          end
          AXIS_Y: begin
            if (sts.zok) begin
              axis_nxt  = AXIS_Z;
              state_nxt = S_RD;
            end else begin
              state_nxt = S_WR;
            end
          end
          default: state_nxt = S_WR;
        endcase
      end
      S_WR: begin
        if (sts.zok) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.axis = axis_r;
    cmd.tap  = tap_r;
    case (state_r)
      S_IDLE:  cmd.load = in_tvalid;
      S_RD:    cmd.rd = 1'b1;
      S_MUL:   cmd.mul = 1'b1;
      S_ACC:   cmd.acc = 1'b1;
      S_RND:   cmd.rnd = 1'b1;
      S_WR:    cmd.wr = 1'b1;
      S_EMIT:  cmd.emit = sts.out_free;
      S_FIN:   cmd.fin = 1'b1;
      default: cmd = '0;
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

### design/srg3d_dp.sv
// Datapath of the restriction unit: configuration, counters, x window,
// shared multiply-accumulate, rounding, store addressing and output register.
// Depends on srg3d_pkg; the stores are external srg3d_ram instances.
module srg3d_dp #(
  parameter int MAX_ROW_LEN = srg3d_pkg::MAX_ROW_LEN_DEF,
  parameter int MAX_ROWS    = srg3d_pkg::MAX_ROWS_DEF,
  parameter int MAX_PLANES  = srg3d_pkg::MAX_PLANES_DEF,
  localparam int CX  = MAX_ROW_LEN / 2,
  localparam int CY  = MAX_ROWS / 2,
  localparam int RAW = $clog2(4 * CX),
  localparam int PAW = $clog2(4 * CX * CY)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [srg3d_pkg::SAMPLE_W-1:0]        in_tdata,
  input  logic                                  in_tlast,
  input  logic                                  cfg_we,
  input  logic [srg3d_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [srg3d_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  srg3d_pkg::cmd_t                       cmd,
  output srg3d_pkg::sts_t                       sts,
  output logic                                  row_re,
  output logic [RAW-1:0]                        row_raddr,
  input  logic [srg3d_pkg::MID_W-1:0]           row_rdata,
  output logic                                  row_we,
  output logic [RAW-1:0]                        row_waddr,
  output logic [srg3d_pkg::MID_W-1:0]           row_wdata,
  output logic                                  plane_re,
  output logic [PAW-1:0]                        plane_raddr,
  input  logic [srg3d_pkg::MID_W-1:0]           plane_rdata,
  output logic                                  plane_we,
  output logic [PAW-1:0]                        plane_waddr,
  output logic [srg3d_pkg::MID_W-1:0]           plane_wdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [srg3d_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import srg3d_pkg::*;

  localparam int XW  = $clog2(MAX_ROW_LEN + 1);
  localparam int YW  = $clog2(MAX_ROWS + 1);
  localparam int ZW  = $clog2(MAX_PLANES + 1);
  localparam int XNW = $clog2(CX);
  localparam int YNW = $clog2(CY);
  localparam int ZNW = $clog2(MAX_PLANES / 2);
  localparam int SH_W = ACC_W - 15;
  localparam logic signed [SH_W-1:0] MAX28 = SH_W'(134217727);
  localparam logic signed [SH_W-1:0] MIN28 = -SH_W'(134217728);
  localparam logic signed [MID_W-1:0] MAX24 = MID_W'(8388607);
  localparam logic signed [MID_W-1:0] MIN24 = -MID_W'(8388608);

  logic [2:0]                    ord_cfg_r;
  logic [8:0]                    len_cfg_r;
  logic [8:0]                    rows_cfg_r;
  logic signed [WT_W-1:0]        wt_r [NUM_TAPS];
  logic [XW-1:0]                 c_r;
  logic [YW-1:0]                 r_r;
  logic [ZW-1:0]                 p_r;
  logic signed [SAMPLE_W-1:0]    xw_r [4];
  logic signed [SAMPLE_W-1:0]    s_r;
  logic                          eog_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [MID_W-1:0]       vx_r;
  logic signed [MID_W-1:0]       vy_r;
  logic                          out_tvalid_r;
  logic [OUT_DATA_W-1:0]         out_tdata_r;

  logic [2:0]                    ord;
  logic [XW-1:0]                 len_q;
  logic [YW-1:0]                 rows_q;
  logic                          xok, yok, zok, drop;
  logic [XNW-1:0]                xn;
  logic [YNW-1:0]                yn;
  logic [ZNW-1:0]                zn;
  logic [2:0]                    widx;
  logic signed [WT_W-1:0]        wsel;
  logic signed [MID_W-1:0]       opnd;
  logic signed [ACC_W-1:0]       rsum;
  logic signed [SH_W-1:0]        shv;
  logic signed [MID_W-1:0]       r28;
  logic signed [MID_W-1:0]       r24;
  logic [1:0]                    rslot, pslot;
  logic [PAW-1:0]                pos;
  logic                          tap_last;
  logic [XW-1:0]                 c_inc;
  logic [YW-1:0]                 r_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ord_cfg_r  <= 3'd2;
      len_cfg_r  <= 9'd256;
      rows_cfg_r <= 9'd256;
      for (int i = 0; i < NUM_TAPS; i++) begin
        wt_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORDER:  ord_cfg_r  <= cfg_data[2:0];
        REG_ROWLEN: len_cfg_r  <= cfg_data[8:0];
        REG_ROWS:   rows_cfg_r <= cfg_data[8:0];
        REG_WT0:    wt_r[0] <= cfg_data;
        REG_WT1:    wt_r[1] <= cfg_data;
        REG_WT2:    wt_r[2] <= cfg_data;
        REG_WT3:    wt_r[3] <= cfg_data;
        REG_WT4:    wt_r[4] <= cfg_data;
        default:    ord_cfg_r <= ord_cfg_r;
      endcase
    end
  end

  always_comb begin
    if (ord_cfg_r < 3'd2) begin
      ord = 3'd2;
    end else if (ord_cfg_r > 3'd4) begin
      ord = 3'd4;
    end else begin
      ord = ord_cfg_r;
    end
    if (len_cfg_r == 9'd0) begin
      len_q = XW'(1);
    end else if (32'(len_cfg_r) > 32'(MAX_ROW_LEN)) begin
      len_q = XW'(MAX_ROW_LEN);
    end else begin
      len_q = XW'(len_cfg_r);
    end
    if (rows_cfg_r == 9'd0) begin
      rows_q = YW'(1);
    end else if (32'(rows_cfg_r) > 32'(MAX_ROWS)) begin
      rows_q = YW'(MAX_ROWS);
    end else begin
      rows_q = YW'(rows_cfg_r);
    end
  end

  assign drop = (p_r >= ZW'(MAX_PLANES));
  assign xok  = (c_r >= XW'(ord)) && (c_r[0] == ord[0]);
  assign yok  = xok && (r_r >= YW'(ord)) && (r_r[0] == ord[0]);
  assign zok  = yok && (p_r >= ZW'(ord)) && (p_r[0] == ord[0]);
  assign xn   = XNW'((c_r - XW'(ord)) >> 1);
  assign yn   = YNW'((r_r - YW'(ord)) >> 1);
  assign zn   = ZNW'((p_r - ZW'(ord)) >> 1);

  assign sts.drop     = drop;
  assign sts.xok      = xok;
  assign sts.yok      = yok;
  assign sts.zok      = zok;
  assign sts.out_free = !out_tvalid_r || out_tready;
  assign sts.ord      = ord;

  assign tap_last = (cmd.tap == ord);
  assign widx     = ord - 3'd1 - cmd.tap;

  always_comb begin
    case (cmd.tap)
      3'd0:    wsel = wt_r[0];
      3'd1:    wsel = wt_r[1];
      3'd2:    wsel = wt_r[2];
      3'd3:    wsel = wt_r[3];
      3'd4:    wsel = wt_r[4];
      default: wsel = '0;
    endcase
    case (cmd.axis)
      AXIS_X:  opnd = tap_last ? MID_W'(s_r) : MID_W'(xw_r[widx[1:0]]);
      AXIS_Y:  opnd = tap_last ? vx_r : $signed(row_rdata);
      AXIS_Z:  opnd = tap_last ? vy_r : $signed(plane_rdata);
      default: opnd = '0;
    endcase
  end

  // Round to nearest, ties upward, then saturate to 28 bits, and further to 24 bits for output.
  always_comb begin
    rsum = acc_r + ACC_W'(16384);
    shv  = SH_W'(rsum >>> 15);
    if (shv > MAX28) begin
      r28 = MAX28[MID_W-1:0];
    end else if (shv < MIN28) begin
      r28 = MIN28[MID_W-1:0];
    end else begin
      r28 = shv[MID_W-1:0];
    end
    if (r28 > MAX24) begin
      r24 = MAX24;
    end else if (r28 < MIN24) begin
      r24 = MIN24;
    end else begin
      r24 = r28;
    end
  end

  assign rslot = r_r[1:0] - ord[1:0] + cmd.tap[1:0];
  assign pslot = p_r[1:0] - ord[1:0] + cmd.tap[1:0];
  assign pos   = PAW'(yn) * PAW'(CX) + PAW'(xn);

  assign row_re      = cmd.rd && (cmd.axis == AXIS_Y);
  assign row_raddr   = RAW'(rslot) * RAW'(CX) + RAW'(xn);
  assign row_we      = cmd.wr;
  assign row_waddr   = RAW'(r_r[1:0]) * RAW'(CX) + RAW'(xn);
  assign row_wdata   = vx_r;
  assign plane_re    = cmd.rd && (cmd.axis == AXIS_Z);
  assign plane_raddr = PAW'(pslot) * PAW'(CX * CY) + pos;
  assign plane_we    = cmd.wr && yok;
  assign plane_waddr = PAW'(p_r[1:0]) * PAW'(CX * CY) + pos;
  assign plane_wdata = vy_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_r   <= in_tdata;
      eog_r <= in_tlast;
    end
    if (cmd.mul) begin
      prod_r <= wsel * opnd;
    end
    if (cmd.acc) begin
      acc_r <= ((cmd.tap == 3'd0) ? ACC_W'(0) : acc_r) + ACC_W'(prod_r);
    end
    if (cmd.rnd) begin
      case (cmd.axis)
        AXIS_X:  vx_r <= r28;
        AXIS_Y:  vy_r <= r28;
        default: vy_r <= vy_r;
      endcase
    end
    if (cmd.emit) begin
      out_tdata_r <= {3'b000, COORD_W'(zn), COORD_W'(yn), COORD_W'(xn),
                      r24[SAMPLE_W-1:0]};
    end
  end

  assign c_inc = c_r + XW'(1);
  assign r_inc = r_r + YW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r          <= '0;
      r_r          <= '0;
      p_r          <= '0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        xw_r[i] <= '0;
      end
    end else begin
      if (cmd.emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cmd.fin) begin
        if (eog_r) begin
          c_r <= '0;
          r_r <= '0;
          p_r <= '0;
          for (int i = 0; i < 4; i++) begin
            xw_r[i] <= '0;
          end
        end else if (!drop) begin
          xw_r[3] <= xw_r[2];
          xw_r[2] <= xw_r[1];
          xw_r[1] <= xw_r[0];
          xw_r[0] <= s_r;
          if (c_inc >= len_q) begin
            c_r <= '0;
            if (r_inc >= rows_q) begin
              r_r <= '0;
              p_r <= p_r + ZW'(1);
            end else begin
              r_r <= r_inc;
            end
          end else begin
            c_r <= c_inc;
          end
        end
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
